>>> src/rpsm_pkg.sv
// Shared types, codes and constants of the redundant peer state monitor.
// No dependencies; imported by every module of the block.
package rpsm_pkg;

	// Event codes
	localparam logic [2:0] CMD_TICK       = 3'd0;
	localparam logic [2:0] CMD_PEER_FRAME = 3'd1;
	localparam logic [2:0] CMD_LINK_DOWN  = 3'd2;
	localparam logic [2:0] CMD_SEND_UNINIT = 3'd3;
	localparam logic [2:0] CMD_CLR_MISMATCH = 3'd4;

	// Peer frame kinds
	localparam logic [1:0] KIND_CHECKSUM = 2'd0;
	localparam logic [1:0] KIND_UNINIT   = 2'd1;

	// Frame kind to send
	localparam logic SEND_CHECKSUM = 1'b0;
	localparam logic SEND_UNINIT   = 1'b1;

	// Tri-state status codes
	localparam logic [1:0] ST_UNKNOWN = 2'd0;
	localparam logic [1:0] ST_YES     = 2'd1;
	localparam logic [1:0] ST_NO      = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] REG_VERSION   = 2'd0;
	localparam logic [1:0] REG_SLOT      = 2'd1;
	localparam logic [1:0] REG_HW_OPTION = 2'd2;
	localparam logic [1:0] REG_COMPAT    = 2'd3;

	localparam logic [15:0] COMPAT_RESET = 16'd1;
	localparam logic [6:0]  TIMER_RESET  = 7'd100;
	localparam logic [6:0]  TIMER_MAX    = 7'd127;
	localparam logic [6:0]  PERIOD_YOUNG = 7'd4;
	localparam logic [6:0]  PERIOD_OLD   = 7'd10;
	localparam logic [14:0] YOUNG_AGE    = 15'd100;
	localparam logic [14:0] FOLD_ABOVE   = 15'd20000;
	localparam logic [14:0] FOLD_TO      = 15'd10000;
	localparam logic [14:0] AGE_MAX      = 15'h7FFF;

	typedef struct packed {
		logic [15:0] version;
		logic [7:0]  slot;
		logic [31:0] hw_option;
		logic [15:0] compat;
	} cfg_t;

	typedef struct packed {
		logic [2:0]  cmd;
		logic        local_active;
		logic [31:0] local_checksum;
		logic [1:0]  msg_kind;
		logic        msg_size_ok;
		logic [31:0] peer_checksum;
		logic [15:0] peer_version;
		logic        peer_active;
		logic [7:0]  peer_slot;
		logic [31:0] peer_hw_option;
		logic        peer_inited;
		logic [15:0] peer_compat;
	} item_t;

	typedef struct packed {
		logic [14:0] link_age;
		logic [6:0]  send_timer;
		logic        self_inited;
		logic [31:0] frames_received;
		logic [31:0] mismatches;
		logic [31:0] own_checksum;
		logic [31:0] twin_checksum;
		logic [15:0] twin_version;
		logic        twin_active;
		logic [7:0]  twin_slot;
		logic [31:0] twin_option;
		logic [15:0] twin_compat;
		logic        twin_inited;
	} mon_state_t;

	// Per-event flags from the state update
	typedef struct packed {
		logic        send_frame;
		logic        send_kind;
		logic [31:0] sent_checksum;
		logic        sent_inited;
		logic        frame_status;
		logic        inited_event;
	} evt_t;

	typedef struct packed {
		evt_t        evt;
		logic [1:0]  match_state;
		logic [1:0]  master_state;
		logic [1:0]  peer_compatible;
		logic [1:0]  peer_active_state;
		logic [1:0]  peer_inited_state;
		logic [31:0] mismatch_count;
	} result_t;

endpackage

>>> src/redundant_peer_state_monitor.sv
// Redundant peer state monitor, top level.
// Path: an accepted request passes from the input register into the result register.
// Throughput: one request per cycle unless out_stall holds a full result register; state update is a single short pass.
// in_stall rises only when the result register is full and out_stall holds it.
// Reset (arst_n low, async): state cleared, send timer to 100, compat reg to 1.
module redundant_peer_state_monitor
	import rpsm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	// request channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  cmd,
	input  logic        local_active,
	input  logic [31:0] local_checksum,
	input  logic [1:0]  msg_kind,
	input  logic        msg_size_ok,
	input  logic [31:0] peer_checksum,
	input  logic [15:0] peer_version,
	input  logic        peer_active,
	input  logic [7:0]  peer_slot,
	input  logic [31:0] peer_hw_option,
	input  logic        peer_inited,
	input  logic [15:0] peer_compat,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic        send_frame,
	output logic        send_kind,
	output logic [31:0] sent_checksum,
	output logic        sent_inited,
	output logic        frame_status,
	output logic        inited_event,
	output logic [1:0]  match_state,
	output logic [1:0]  master_state,
	output logic [1:0]  peer_compatible,
	output logic [1:0]  peer_active_state,
	output logic [1:0]  peer_inited_state,
	output logic [31:0] mismatch_count
);

	cfg_t       cfg;
	item_t      item_s1;
	logic       valid_s1;
	result_t    res_s2;
	logic       valid_s2;
	logic       advance;
	logic       in_take;
	mon_state_t st_next;
	evt_t       evt;
	result_t    res;

	// stage 1 moves on when the result register is empty or being drained
	assign advance  = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	rpsm_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (!valid_s1 || advance)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1.cmd            <= cmd;
			item_s1.local_active   <= local_active;
			item_s1.local_checksum <= local_checksum;
			item_s1.msg_kind       <= msg_kind;
			item_s1.msg_size_ok    <= msg_size_ok;
			item_s1.peer_checksum  <= peer_checksum;
			item_s1.peer_version   <= peer_version;
			item_s1.peer_active    <= peer_active;
			item_s1.peer_slot      <= peer_slot;
			item_s1.peer_hw_option <= peer_hw_option;
			item_s1.peer_inited    <= peer_inited;
			item_s1.peer_compat    <= peer_compat;
		end
	end

	// state update commits as the request moves into the result register
	rpsm_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.commit  (valid_s1 && advance),
		.item    (item_s1),
		.cfg     (cfg),
		.st_next (st_next),
		.evt     (evt)
	);

	rpsm_status u_status (
		.st           (st_next),
		.cfg          (cfg),
		.local_active (item_s1.local_active),
		.evt          (evt),
		.res          (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (advance)
			valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1)
			res_s2 <= res;
	end

	assign out_valid         = valid_s2;
	assign send_frame        = res_s2.evt.send_frame;
	assign send_kind         = res_s2.evt.send_kind;
	assign sent_checksum     = res_s2.evt.sent_checksum;
	assign sent_inited       = res_s2.evt.sent_inited;
	assign frame_status      = res_s2.evt.frame_status;
	assign inited_event      = res_s2.evt.inited_event;
	assign match_state       = res_s2.match_state;
	assign master_state      = res_s2.master_state;
	assign peer_compatible   = res_s2.peer_compatible;
	assign peer_active_state = res_s2.peer_active_state;
	assign peer_inited_state = res_s2.peer_inited_state;
	assign mismatch_count    = res_s2.mismatch_count;

endmodule

>>> src/rpsm_cfg.sv
// Configuration register file of the peer state monitor.
// Depends on rpsm_pkg for cfg_t and register indexes.
module rpsm_cfg
	import rpsm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output cfg_t        cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.version   <= '0;
			cfg_q.slot      <= '0;
			cfg_q.hw_option <= '0;
			cfg_q.compat    <= COMPAT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_VERSION:   cfg_q.version   <= cfg_data[15:0];
				REG_SLOT:      cfg_q.slot      <= cfg_data[7:0];
				REG_HW_OPTION: cfg_q.hw_option <= cfg_data;
				REG_COMPAT:    cfg_q.compat    <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> src/rpsm_core.sv
// Monitor state registers and their per-request update.
// Depends on rpsm_pkg for item, state and event types.
module rpsm_core
	import rpsm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       commit,
	input  item_t      item,
	input  cfg_t       cfg,
	output mon_state_t st_next,
	output evt_t       evt
);

	localparam mon_state_t ST_RESET = '{send_timer: TIMER_RESET, default: '0};

	mon_state_t st_q;
	mon_state_t nx;
	evt_t       ev;
	logic [6:0]  limit;
	logic [14:0] age_inc;
	logic        same;
	logic [31:0] mis_base;

	always_comb begin
		nx       = st_q;
		ev       = '0;
		limit    = (st_q.link_age > YOUNG_AGE) ? PERIOD_OLD : PERIOD_YOUNG;
		age_inc  = (st_q.link_age < AGE_MAX) ? st_q.link_age + 15'd1 : st_q.link_age;
		same     = (item.peer_version == cfg.version) &&
		           (item.peer_hw_option == cfg.hw_option);
		mis_base = item.msg_size_ok ? st_q.mismatches : 32'd0;
		case (item.cmd)
			CMD_TICK: begin
				nx.link_age = age_inc;
				if (st_q.send_timer != TIMER_MAX)
					nx.send_timer = st_q.send_timer + 7'd1;
				if (st_q.send_timer >= limit) begin
					nx.send_timer    = '0;
					nx.own_checksum  = item.local_checksum;
					ev.send_frame    = 1'b1;
					ev.send_kind     = SEND_CHECKSUM;
					ev.sent_checksum = item.local_checksum;
					ev.sent_inited   = st_q.self_inited;
					if (age_inc > FOLD_ABOVE)
						nx.link_age = FOLD_TO;
				end else if (!st_q.self_inited && item.local_active) begin
					nx.self_inited  = 1'b1;
					nx.send_timer   = TIMER_RESET;
					ev.inited_event = 1'b1;
				end
			end
			CMD_PEER_FRAME: begin
				if (item.msg_kind inside {KIND_CHECKSUM, KIND_UNINIT}) begin
					nx.twin_checksum = item.peer_checksum;
					nx.twin_version  = item.peer_version;
					nx.twin_active   = item.peer_active;
					nx.twin_slot     = item.peer_slot;
					nx.twin_option   = item.peer_hw_option;
					nx.twin_inited   = item.peer_inited;
					nx.twin_compat   = item.peer_compat;
					if (st_q.frames_received != '1)
						nx.frames_received = st_q.frames_received + 32'd1;
					if (!same)
						nx.mismatches = '0;
					else if (item.peer_checksum != st_q.own_checksum)
						nx.mismatches = (mis_base != '1) ? mis_base + 32'd1 : mis_base;
					else
						nx.mismatches = '0;
					if (item.msg_kind == KIND_UNINIT) begin
						nx.self_inited = 1'b0;
						nx.send_timer  = TIMER_RESET;
					end else begin
						ev.frame_status = !item.msg_size_ok;
					end
				end else begin
					ev.frame_status = 1'b1;
				end
			end
			CMD_LINK_DOWN: begin
				nx.frames_received = '0;
				nx.twin_inited     = 1'b0;
				nx.link_age        = '0;
			end
			CMD_SEND_UNINIT: begin
				nx.send_timer    = '0;
				nx.own_checksum  = item.local_checksum;
				ev.send_frame    = 1'b1;
				ev.send_kind     = SEND_UNINIT;
				ev.sent_checksum = item.local_checksum;
				ev.sent_inited   = st_q.self_inited;
			end
			CMD_CLR_MISMATCH: nx.mismatches = '0;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_RESET;
		end else if (commit) begin
			st_q <= nx;
		end
	end

	assign st_next = nx;
	assign evt     = ev;

endmodule

>>> src/rpsm_status.sv
// Match, compatibility and master election status from the updated state.
// Depends on rpsm_pkg for state, config, event and result types.
module rpsm_status
	import rpsm_pkg::*;
(
	input  mon_state_t st,
	input  cfg_t       cfg,
	input  logic       local_active,
	input  evt_t       evt,
	output result_t    res
);

	logic seen;
	logic same;

	always_comb begin
		seen = (st.frames_received != '0);
		same = (st.twin_version == cfg.version) && (st.twin_option == cfg.hw_option);
		res.evt            = evt;
		res.mismatch_count = st.mismatches;
		if (!seen) begin
			res.match_state       = ST_UNKNOWN;
			res.peer_compatible   = ST_UNKNOWN;
			res.peer_active_state = ST_UNKNOWN;
			res.peer_inited_state = ST_UNKNOWN;
		end else begin
			res.match_state       = (same && st.twin_checksum == st.own_checksum) ?
			                        ST_YES : ST_NO;
			res.peer_compatible   = (same && st.twin_compat == cfg.compat) ? ST_YES : ST_NO;
			res.peer_active_state = st.twin_active ? ST_YES : ST_NO;
			res.peer_inited_state = st.twin_inited ? ST_YES : ST_NO;
		end
		// master: ST_YES = this card, ST_NO = peer
		if (local_active)
			res.master_state = ST_YES;
		else if (seen && st.twin_active)
			res.master_state = ST_NO;
		else if (!seen)
			res.master_state = ST_UNKNOWN;
		else if (st.twin_inited && !st.self_inited)
			res.master_state = ST_NO;
		else if (!st.twin_inited && st.self_inited)
			res.master_state = ST_YES;
		else if (cfg.slot < st.twin_slot)
			res.master_state = ST_YES;
		else
			res.master_state = ST_UNKNOWN;
	end

endmodule
